// ===== rtl/core/pfc_pkg.sv =====
// Shared types and constants for the packet frame checker.
// Depends on nothing; every other file of the block but pfc_if refers to it by scoped names.
package pfc_pkg;

    localparam int unsigned HEADER_BYTES = 14;
    localparam int unsigned CRC_BYTES    = 2;
    localparam int unsigned MIN_FRAME    = HEADER_BYTES + CRC_BYTES;

    localparam int unsigned CNT_W = 9;
    localparam int unsigned LEN_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // header byte offsets
    localparam logic [CNT_W-1:0] OFS_MAGIC = CNT_W'(0);
    localparam logic [CNT_W-1:0] OFS_TYPE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] OFS_ACK   = CNT_W'(2);
    localparam logic [CNT_W-1:0] OFS_SRC   = CNT_W'(3);
    localparam logic [CNT_W-1:0] OFS_DST   = CNT_W'(7);
    localparam logic [CNT_W-1:0] OFS_SEQ   = CNT_W'(11);
    localparam logic [CNT_W-1:0] OFS_LEN   = CNT_W'(13);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [7:0] MAGIC_RESET   = 8'd0;
    localparam logic [7:0] MAX_LEN_RESET = 8'd255;

    // configuration register indexes
    localparam logic CFG_MAGIC_VALUE     = 1'b0;
    localparam logic CFG_MAX_PAYLOAD_LEN = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_LEN_MISM  = 3'd4,
        ST_CRC_MISM  = 3'd5
    } t_status;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        verdict_valid;
        t_status     status;
        logic [7:0]  frame_type;
        logic [7:0]  ack_req;
        logic [31:0] src_node;
        logic [31:0] dst_node;
        logic [15:0] sequence_res;
        logic [7:0]  declared_len;
    } t_result;

endpackage

// ===== rtl/core/pfc_if.sv =====
// Channel interfaces of the packet frame checker: received bytes in, per-byte results out.
// Depends on nothing.
interface pfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface pfc_result_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        verdict_valid;
    logic [2:0]  status;
    logic [7:0]  frame_type;
    logic [7:0]  ack_req;
    logic [31:0] src_node;
    logic [31:0] dst_node;
    logic [15:0] sequence_res;
    logic [7:0]  declared_len;

    modport source (output valid, output payload_valid, output payload_byte,
                    output verdict_valid, output status, output frame_type,
                    output ack_req, output src_node, output dst_node,
                    output sequence_res, output declared_len, input ready);
    modport sink   (input valid, input payload_valid, input payload_byte,
                    input verdict_valid, input status, input frame_type,
                    input ack_req, input src_node, input dst_node,
                    input sequence_res, input declared_len, output ready);
endinterface

// ===== rtl/core/pfc_crc16.sv =====
// One-byte update of CRC16-CCITT, MSB first, eight shift steps unrolled.
// Depends on pfc_pkg for the polynomial.
module pfc_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((v_crc & pfc_pkg::CRC_MSB) != 16'h0000) begin
                v_crc = {v_crc[14:0], 1'b0} ^ pfc_pkg::CRC_POLY;
            end else begin
                v_crc = {v_crc[14:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

// ===== rtl/core/pfc_skid.sv =====
// Output register with a skid stage for the per-byte result.
// Depends on pfc_pkg for the result type.
module pfc_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pfc_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output pfc_pkg::t_result o_data
);

    logic             r_out_valid;
    pfc_pkg::t_result r_out;
    logic             r_skid_valid;
    pfc_pkg::t_result r_skid;
    logic             w_in_fire;
    logic             w_out_fire;

    assign o_ready    = !r_skid_valid;
    assign w_in_fire  = i_valid && !r_skid_valid;
    assign w_out_fire = r_out_valid && i_ready;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_in_fire) begin
            if (!r_out_valid || w_out_fire) begin
                r_out_valid <= 1'b1;
                r_out       <= i_data;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid       <= i_data;
            end
        end else if (w_out_fire) begin
            // drain the skid stage first, else empty the output
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/packet_frame_checker.sv =====
// Each result is registered in the output register, or in the skid register while
//   the output is stalled. One byte per cycle while the skid register is empty;
//   header capture, CRC byte update and the verdict sit before the result register.
// A two-entry output stage keeps accepting while one result waits to be taken.
// Reset (synchronous, active low): frame state to its start values, CRC to 0xFFFF,
//   magic_value to 0, max_payload_len to 255, no result pending.
module packet_frame_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pfc_byte_if.sink     i_in,
    pfc_result_if.source o_out,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [7:0]   i_cfg_data
);

    localparam int unsigned CNT_W = pfc_pkg::CNT_W;
    localparam int unsigned LEN_W = pfc_pkg::LEN_W;

    // configuration
    logic [7:0] r_magic_value;
    logic [7:0] r_max_payload_len;

    // frame state
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]      r_crc, n_crc;
    logic [15:0]      r_delay, n_delay;
    logic [7:0]       r_hdr_magic, n_hdr_magic;
    logic [7:0]       r_hdr_type, n_hdr_type;
    logic [7:0]       r_hdr_ack, n_hdr_ack;
    logic [31:0]      r_hdr_src, n_hdr_src;
    logic [31:0]      r_hdr_dst, n_hdr_dst;
    logic [15:0]      r_hdr_seq, n_hdr_seq;
    logic [7:0]       r_hdr_len, n_hdr_len;

    logic             w_in_ready;
    logic             w_in_fire;
    logic [7:0]       w_byte;
    logic             w_last;
    logic [15:0]      w_crc_upd;
    logic [15:0]      w_rx_crc;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_expect_len;
    logic [CNT_W-1:0] w_pay_ofs;
    pfc_pkg::t_result w_result;
    pfc_pkg::t_result w_out_data;
    logic             w_out_valid;

    assign w_byte    = i_in.rx_byte;
    assign w_last    = i_in.end_of_frame;
    assign i_in.ready = w_in_ready;
    assign w_in_fire = i_in.valid && w_in_ready;

    // Configuration writes; an index past the list cannot occur with a one-bit index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_value     <= pfc_pkg::MAGIC_RESET;
            r_max_payload_len <= pfc_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pfc_pkg::CFG_MAGIC_VALUE:     r_magic_value     <= i_cfg_data;
                pfc_pkg::CFG_MAX_PAYLOAD_LEN: r_max_payload_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // CRC runs over the byte leaving the two-byte delay line
    pfc_crc16 u_crc16 (
        .i_crc  (r_crc),
        .i_byte (r_delay[15:8]),
        .o_crc  (w_crc_upd)
    );

    always_comb begin
        // header capture: each header position lands in its own byte lane
        n_hdr_magic = r_hdr_magic;
        n_hdr_type  = r_hdr_type;
        n_hdr_ack   = r_hdr_ack;
        n_hdr_src   = r_hdr_src;
        n_hdr_dst   = r_hdr_dst;
        n_hdr_seq   = r_hdr_seq;
        n_hdr_len   = r_hdr_len;
        if (r_byte_count == pfc_pkg::OFS_MAGIC) begin
            n_hdr_magic = w_byte;
        end else if (r_byte_count == pfc_pkg::OFS_TYPE) begin
            n_hdr_type = w_byte;
        end else if (r_byte_count == pfc_pkg::OFS_ACK) begin
            n_hdr_ack = w_byte;
        end else if (r_byte_count >= pfc_pkg::OFS_SRC && r_byte_count < pfc_pkg::OFS_DST) begin
            n_hdr_src[8*(2'(r_byte_count - pfc_pkg::OFS_SRC)) +: 8] = w_byte;
        end else if (r_byte_count >= pfc_pkg::OFS_DST && r_byte_count < pfc_pkg::OFS_SEQ) begin
            n_hdr_dst[8*(2'(r_byte_count - pfc_pkg::OFS_DST)) +: 8] = w_byte;
        end else if (r_byte_count >= pfc_pkg::OFS_SEQ && r_byte_count < pfc_pkg::OFS_LEN) begin
            n_hdr_seq[8*(1'(r_byte_count - pfc_pkg::OFS_SEQ)) +: 8] = w_byte;
        end else if (r_byte_count == pfc_pkg::OFS_LEN) begin
            n_hdr_len = w_byte;
        end

        // advance CRC only once the line holds two bytes
        n_crc   = (r_byte_count >= CNT_W'(2)) ? w_crc_upd : r_crc;
        n_delay = {r_delay[7:0], w_byte};
        // received CRC: low byte first on the wire
        w_rx_crc = {w_byte, r_delay[7:0]};

        // saturate the counter
        n_byte_count = (r_byte_count != pfc_pkg::COUNT_MAX) ? r_byte_count + CNT_W'(1)
                                                              : r_byte_count;

        w_len        = LEN_W'(r_byte_count) + LEN_W'(1);
        w_expect_len = LEN_W'(pfc_pkg::MIN_FRAME) + LEN_W'(n_hdr_len);
        w_pay_ofs    = r_byte_count - CNT_W'(pfc_pkg::HEADER_BYTES);

        w_result = '0;
        if (r_byte_count >= CNT_W'(pfc_pkg::HEADER_BYTES)
                && w_pay_ofs < CNT_W'(r_hdr_len)) begin
            w_result.payload_valid = 1'b1;
            w_result.payload_byte  = w_byte;
        end
        if (w_last) begin
            w_result.verdict_valid = 1'b1;
            if (w_len < LEN_W'(pfc_pkg::MIN_FRAME)) begin
                w_result.status = pfc_pkg::ST_TOO_SHORT;
            end else if (n_hdr_magic != r_magic_value) begin
                w_result.status = pfc_pkg::ST_BAD_MAGIC;
            end else if (n_hdr_len > r_max_payload_len) begin
                w_result.status = pfc_pkg::ST_TOO_LONG;
            end else if (w_len != w_expect_len) begin
                w_result.status = pfc_pkg::ST_LEN_MISM;
            end else if (w_rx_crc != n_crc) begin
                w_result.status = pfc_pkg::ST_CRC_MISM;
            end else begin
                w_result.status = pfc_pkg::ST_OK;
            end
            w_result.frame_type   = n_hdr_type;
            w_result.ack_req      = n_hdr_ack;
            w_result.src_node     = n_hdr_src;
            w_result.dst_node     = n_hdr_dst;
            w_result.sequence_res = n_hdr_seq;
            w_result.declared_len = n_hdr_len;
        end
    end

    // Frame state: advance on every accepted byte, drop back to start after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_in_fire && w_last)) begin
            r_byte_count <= '0;
            r_crc        <= pfc_pkg::CRC_INIT;
            r_delay      <= '0;
            r_hdr_magic  <= '0;
            r_hdr_type   <= '0;
            r_hdr_ack    <= '0;
            r_hdr_src    <= '0;
            r_hdr_dst    <= '0;
            r_hdr_seq    <= '0;
            r_hdr_len    <= '0;
        end else if (w_in_fire) begin
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
            r_delay      <= n_delay;
            r_hdr_magic  <= n_hdr_magic;
            r_hdr_type   <= n_hdr_type;
            r_hdr_ack    <= n_hdr_ack;
            r_hdr_src    <= n_hdr_src;
            r_hdr_dst    <= n_hdr_dst;
            r_hdr_seq    <= n_hdr_seq;
            r_hdr_len    <= n_hdr_len;
        end
    end

    // Hold results in the output stage until the sink takes each transaction.
    pfc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_in_ready),
        .i_data  (w_result),
        .o_valid (w_out_valid),
        .i_ready (o_out.ready),
        .o_data  (w_out_data)
    );

    assign o_out.valid         = w_out_valid;
    assign o_out.payload_valid = w_out_data.payload_valid;
    assign o_out.payload_byte  = w_out_data.payload_byte;
    assign o_out.verdict_valid = w_out_data.verdict_valid;
    assign o_out.status        = w_out_data.status;
    assign o_out.frame_type    = w_out_data.frame_type;
    assign o_out.ack_req       = w_out_data.ack_req;
    assign o_out.src_node      = w_out_data.src_node;
    assign o_out.dst_node      = w_out_data.dst_node;
    assign o_out.sequence_res  = w_out_data.sequence_res;
    assign o_out.declared_len  = w_out_data.declared_len;

endmodule

// ===== rtl/core/pfc_checker.sv =====
// Port-level assertions for the packet frame checker, attached by a bind.
// Depends on pfc_pkg for status codes and on packet_frame_checker's ports.
module pfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_payload_valid,
    input logic [7:0]  i_payload_byte,
    input logic        i_verdict_valid,
    input logic [2:0]  i_status,
    input logic [7:0]  i_declared_len,
    input logic [31:0] i_src_node
);

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    a_status_only_on_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_verdict_valid) |->
            (i_status == pfc_pkg::ST_OK && i_declared_len == 8'd0 && i_src_node == 32'd0))
        else $error("header or status reported without a verdict");

    a_payload_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_payload_valid) |-> (i_payload_byte == 8'd0))
        else $error("payload byte nonzero outside the payload");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
            && $stable(i_payload_byte)))
        else $error("stalled result changed");

endmodule

bind packet_frame_checker pfc_checker u_pfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_payload_valid (o_out.payload_valid),
    .i_payload_byte  (o_out.payload_byte),
    .i_verdict_valid (o_out.verdict_valid),
    .i_status        (o_out.status),
    .i_declared_len  (o_out.declared_len),
    .i_src_node      (o_out.src_node)
);
